@@ src/sfd_pkg.sv @@
// shared types and constants of the shunt frame decoder
package sfd_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'hA5;
    localparam logic [3:0]  CHECK_POS     = 4'd15;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
    localparam logic [31:0] AGE_MAX       = 32'hFFFF_FFFF;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TICK    = 1'b1;
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_ONLINE = 1'b1;

    localparam int  PADDR_W     = 3;
    localparam logic REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [7:0]         charge_percent;
        logic [15:0]        pack_cvolt;
        logic [31:0]        cap_left_mah;
        logic signed [31:0] pack_milliamp;
        logic [23:0]        remaining_s;
        logic signed [47:0] power_raw;
        logic [46:0]        chg_power;
        logic [46:0]        dchg_power;
        logic               online;
    } t_out_item;

endpackage

@@ src/shunt_frame_decoder.sv @@
// shunt frame decoder: frame assembly, checksum, link aging and power split
//
// channel  | valid      | ready       | payload
// ---------+------------+-------------+-------------------------
// input    | i_in_valid | o_in_ready  | i_in_item (t_in_item)
// output   | o_out_valid| i_out_ready | o_out_item (t_out_item)
// config   | psel&penable&pwrite     | pready=1 | paddr, pwdata, prdata
//
// one item accepted per cycle while the output is not stalled; a result passes
// through the decode register, multiply register and output register
// the 16x32 power multiply sets the depth, not the rate
// reset clears frame position, sum, age and link flags; timeout to 10000
// a stalled output backs up through the three stages to o_in_ready
module shunt_frame_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sfd_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sfd_pkg::t_out_item          o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sfd_pkg::*;

    logic [31:0] r_timeout;
    logic [3:0]  r_pos;
    logic [7:0]  r_frame [1:14];
    logic [7:0]  r_sum;
    logic [31:0] r_age;
    logic        r_seen;
    logic        r_online;
    logic        r_reported;

    logic        r_a_valid, r_b_valid, r_c_valid;
    t_out_item   r_a, r_b, r_c;

    logic        a_ready, b_ready, c_ready;
    logic        accept;
    logic [31:0] n_age_tick;
    logic        now_online;
    logic        emit;
    t_out_item   n_a;
    t_out_item   n_b;
    t_out_item   n_c;
    logic signed [16:0] cv_s;
    logic signed [48:0] prod;
    logic [47:0] neg_power;

    // apb
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_TIMEOUT) ? r_timeout : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_TIMEOUT) begin
            r_timeout <= pwdata;
        end
    end

    // handshake chain
    assign c_ready    = i_out_ready || !r_c_valid;
    assign b_ready    = c_ready || !r_b_valid;
    assign a_ready    = b_ready || !r_a_valid;
    assign o_in_ready = a_ready;
    assign accept     = i_in_valid && a_ready;

    // decode of one item
    assign n_age_tick = (r_age == AGE_MAX) ? r_age : r_age + 32'd1;
    assign now_online = r_seen && (n_age_tick <= r_timeout);

    always_comb begin
        emit = 1'b0;
        n_a  = '0;
        if (i_in_item.cmd == CMD_TICK) begin
            emit          = !r_reported || (now_online != r_online);
            n_a.kind      = KIND_ONLINE;
            n_a.online    = now_online;
        end else begin
            emit               = (r_pos == CHECK_POS) && (r_sum == i_in_item.rx_byte);
            n_a.kind           = KIND_FRAME;
            n_a.charge_percent = r_frame[1];
            n_a.pack_cvolt     = {r_frame[2], r_frame[3]};
            n_a.cap_left_mah   = {r_frame[4], r_frame[5], r_frame[6], r_frame[7]};
            n_a.pack_milliamp  = {r_frame[8], r_frame[9], r_frame[10], r_frame[11]};
            n_a.remaining_s    = {r_frame[12], r_frame[13], r_frame[14]};
            n_a.online         = r_online;
        end
    end

    // frame and link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_age      <= '0;
            r_seen     <= 1'b0;
            r_online   <= 1'b0;
            r_reported <= 1'b0;
        end else if (accept) begin
            if (i_in_item.cmd == CMD_TICK) begin
                r_age <= n_age_tick;
                if (emit) begin
                    r_online   <= now_online;
                    r_reported <= 1'b1;
                end
            end else begin
                priority if (r_pos == '0) begin
                    if (i_in_item.rx_byte == SYNC_BYTE) begin
                        r_sum <= SYNC_BYTE;
                        r_pos <= 4'd1;
                    end
                end else if (r_pos != CHECK_POS) begin
                    r_sum <= r_sum + i_in_item.rx_byte;
                    r_pos <= r_pos + 4'd1;
                end else begin
                    r_pos <= '0;
                    r_sum <= '0;
                    if (emit) begin
                        r_age  <= '0;
                        r_seen <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.cmd == CMD_BYTE && r_pos != '0 && r_pos != CHECK_POS) begin
            r_frame[r_pos] <= i_in_item.rx_byte;
        end
    end

    // decode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a <= n_a;
        end
    end

    // multiply register
    assign cv_s = $signed({1'b0, r_a.pack_cvolt});
    assign prod = cv_s * r_a.pack_milliamp;

    always_comb begin
        n_b           = r_a;
        n_b.power_raw = prod[47:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready) begin
            r_b <= n_b;
        end
    end

    // output register with power split
    assign neg_power = 48'd0 - r_b.power_raw;

    always_comb begin
        n_c            = r_b;
        n_c.chg_power  = (!r_b.power_raw[47] && r_b.power_raw != '0)
                         ? r_b.power_raw[46:0] : 47'd0;
        n_c.dchg_power = r_b.power_raw[47] ? neg_power[46:0] : 47'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready) begin
            r_c <= n_c;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_item  = r_c;

    // checks
    a_report_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_ONLINE |->
            o_out_item.power_raw == '0 && o_out_item.cap_left_mah == '0)
        else $error("online report carries frame data");

    a_split_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_item.chg_power == '0 || o_out_item.dchg_power == '0)
        else $error("charging and discharging both nonzero");

    a_tick_keeps_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_item.cmd == CMD_TICK |=> $stable(r_pos) && $stable(r_sum))
        else $error("tick disturbed frame assembly");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_b_valid && r_c_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken with full pipeline");

endmodule

@@ tb/shunt_frame_decoder_tb.sv @@
// self-checking testbench of the shunt frame decoder: directed script, then random frames and ticks
module shunt_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_DOWN,
        CHK_UP
    } t_chk;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       fix_sum;
        t_chk       chk;
    } t_row;

    localparam int SCRIPT_LEN = 23;
    localparam int NUM_PHASES = 5;
    localparam int PHASE_ITEMS = 180;
    localparam int SPARE_INDEX = 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS = 40;
    localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = PADDR_W'(4 * REG_TIMEOUT);
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4 * SPARE_INDEX);

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    logic [3:0]  asm_pos;
    logic [7:0]  asm_bytes [15];
    logic [7:0]  asm_sum;
    logic [31:0] link_age;
    logic        link_seen;
    logic        link_online;
    logic        link_reported;
    logic [31:0] link_timeout;

    t_out_item   pending_results [$];
    t_row        script [SCRIPT_LEN];
    logic [31:0] phase_timeout [NUM_PHASES];

    int err_count;
    int n_items;
    int n_frames;
    int n_reports;
    int n_dropped;
    int gap_pct;
    int phase_no;
    bit calm;
    bit squeezed;

    shunt_frame_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < MAX_PRINTS) begin
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        end
        err_count++;
    endtask

    task automatic cmp(input string what, input logic [63:0] got, input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic decode_step(input t_in_item it, output bit has_res, output t_out_item res,
                               output bit ignored);
        logic [15:0]        volt;
        logic signed [31:0] cur;
        longint             prod;
        longint             mag;
        bit                 now_online;
        has_res = 1'b0;
        ignored = 1'b0;
        res = '0;
        if (it.cmd == CMD_BYTE) begin
            if (asm_pos == 4'd0) begin
                if (it.rx_byte != SYNC_BYTE) begin
                    ignored = 1'b1;
                end else begin
                    asm_bytes[0] = it.rx_byte;
                    asm_sum = it.rx_byte;
                    asm_pos = 4'd1;
                end
            end else if (asm_pos < CHECK_POS) begin
                asm_bytes[asm_pos] = it.rx_byte;
                asm_sum = asm_sum + it.rx_byte;
                asm_pos = asm_pos + 4'd1;
            end else begin
                asm_pos = 4'd0;
                if (asm_sum != it.rx_byte) begin
                    n_dropped++;
                end else begin
                    link_age = '0;
                    link_seen = 1'b1;
                    volt = {asm_bytes[2], asm_bytes[3]};
                    cur = {asm_bytes[8], asm_bytes[9], asm_bytes[10], asm_bytes[11]};
                    prod = longint'(volt) * longint'(cur);
                    mag = -prod;
                    res.kind = KIND_FRAME;
                    res.charge_percent = asm_bytes[1];
                    res.pack_cvolt = volt;
                    res.cap_left_mah = {asm_bytes[4], asm_bytes[5], asm_bytes[6], asm_bytes[7]};
                    res.pack_milliamp = cur;
                    res.remaining_s = {asm_bytes[12], asm_bytes[13], asm_bytes[14]};
                    res.power_raw = prod[47:0];
                    res.chg_power = (prod > 0) ? prod[46:0] : '0;
                    res.dchg_power = (prod < 0) ? mag[46:0] : '0;
                    res.online = link_online;
                    has_res = 1'b1;
                    n_frames++;
                end
                asm_sum = '0;
            end
        end else begin
            if (link_age != AGE_MAX) begin
                link_age = link_age + 32'd1;
            end
            now_online = link_seen && (link_age <= link_timeout);
            if (!(link_reported && now_online == link_online)) begin
                link_online = now_online;
                link_reported = 1'b1;
                res.kind = KIND_ONLINE;
                res.online = now_online;
                has_res = 1'b1;
                n_reports++;
            end
        end
    endtask

    task automatic offer(input t_in_item it, input t_chk chk);
        bit        has_res;
        bit        ignored;
        t_out_item res;
        if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        decode_step(it, has_res, res, ignored);
        case (chk)
            CHK_MODEL: begin
                if (has_res) pending_results.push_back(res);
            end
            CHK_DOWN, CHK_UP: begin
                res = '0;
                res.kind = KIND_ONLINE;
                res.online = (chk == CHK_UP);
                pending_results.push_back(res);
            end
            default: ;
        endcase
        if (!ignored) n_items++;
        @(negedge i_clk);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with none expected", got.kind, '0);
        end else begin
            want = pending_results.pop_front();
            cmp("kind", got.kind, want.kind);
            cmp("charge_percent", got.charge_percent, want.charge_percent);
            cmp("pack_cvolt", got.pack_cvolt, want.pack_cvolt);
            cmp("cap_left_mah", got.cap_left_mah, want.cap_left_mah);
            cmp("pack_milliamp", got.pack_milliamp, want.pack_milliamp);
            cmp("remaining_s", got.remaining_s, want.remaining_s);
            cmp("power_raw", got.power_raw, want.power_raw);
            cmp("chg_power", got.chg_power, want.chg_power);
            cmp("dchg_power", got.dchg_power, want.dchg_power);
            cmp("online", got.online, want.online);
        end
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == TIMEOUT_ADDR) link_timeout = data;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return SYNC_BYTE;
            3: return 8'h80;
            4: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_frame(input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        while (asm_pos != 4'd0) begin
            offer(t_in_item'{CMD_BYTE, pick_byte()}, CHK_MODEL);
        end
        sum = SYNC_BYTE;
        offer(t_in_item'{CMD_BYTE, SYNC_BYTE}, CHK_MODEL);
        for (int i = 1; i < 15; i++) begin
            b = pick_byte();
            sum = sum + b;
            offer(t_in_item'{CMD_BYTE, b}, CHK_MODEL);
            if ($urandom_range(99) < 8) begin
                offer(t_in_item'{CMD_TICK, 8'($urandom)}, CHK_MODEL);
            end
        end
        if (!good) sum = sum + 8'($urandom_range(1, 255));
        offer(t_in_item'{CMD_BYTE, sum}, CHK_MODEL);
    endtask

    task automatic send_partial();
        int k;
        k = $urandom_range(0, 13);
        offer(t_in_item'{CMD_BYTE, SYNC_BYTE}, CHK_MODEL);
        repeat (k) offer(t_in_item'{CMD_BYTE, pick_byte()}, CHK_MODEL);
    endtask

    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            if (b == SYNC_BYTE) b = 8'h00;
            offer(t_in_item'{CMD_BYTE, b}, CHK_MODEL);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result(o_out_item);
        end
    end

    initial begin
        int stall_pct;
        int span;
        int cyc;
        i_out_ready = 1'b0;
        stall_pct = 0;
        cyc = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                case ($urandom_range(3))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            if (!squeezed && phase_no == 1) begin
                squeezed = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(99) < stall_pct) begin
                i_out_ready <= 1'b0;
                span = $urandom_range(1, 18);
                repeat (span - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("shunt_frame_decoder_tb NOT OK");
        $finish;
    end

    initial begin
        t_row       row;
        logic [7:0] b;
        int         goal;
        int         pick;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        err_count = 0;
        n_items = 0;
        n_frames = 0;
        n_reports = 0;
        n_dropped = 0;
        gap_pct = 0;
        phase_no = -1;
        calm = 1'b0;
        squeezed = 1'b0;
        asm_pos = '0;
        asm_sum = '0;
        link_age = '0;
        link_seen = 1'b0;
        link_online = 1'b0;
        link_reported = 1'b0;
        link_timeout = TIMEOUT_RESET;
        for (int i = 0; i < 15; i++) asm_bytes[i] = '0;
        phase_timeout = '{32'd0, 32'd6, 32'hFFFF_FFFF, 32'd25, 32'd3};
        script = '{
            '{CMD_TICK, 8'h00, 1'b0, CHK_DOWN},
            '{CMD_TICK, 8'hFF, 1'b0, CHK_NONE},
            '{CMD_BYTE, 8'h00, 1'b0, CHK_NONE},
            '{CMD_BYTE, 8'hFF, 1'b0, CHK_NONE},
            '{CMD_BYTE, SYNC_BYTE, 1'b0, CHK_NONE},
            '{CMD_BYTE, 8'h64, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'hFF, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'hFF, 1'b0, CHK_MODEL},
            '{CMD_TICK, 8'h5A, 1'b0, CHK_NONE},
            '{CMD_BYTE, SYNC_BYTE, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'hFF, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'h00, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'h01, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'h80, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'h00, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'h00, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'h00, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'hFF, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'hFF, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'hFF, 1'b0, CHK_MODEL},
            '{CMD_BYTE, 8'h00, 1'b1, CHK_MODEL},
            '{CMD_TICK, 8'h00, 1'b0, CHK_UP},
            '{CMD_TICK, 8'h00, 1'b0, CHK_NONE}
        };
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            row = script[r];
            b = row.fix_sum ? asm_sum : row.data;
            offer(t_in_item'{row.cmd, b}, row.chk);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_reg(TIMEOUT_ADDR, phase_timeout[p]);
            // write to an unmapped slot must leave the timeout alone
            if (p == 1) write_reg(SPARE_ADDR, 32'd1);
            calm = (p == NUM_PHASES - 1);
            phase_no = p;
            goal = n_items + PHASE_ITEMS;
            while (n_items < goal) begin
                case ($urandom_range(3))
                    0, 1: gap_pct = 0;
                    2: gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                pick = $urandom_range(99);
                if (pick < 60) send_frame(1'b1);
                else if (pick < 72) send_frame(1'b0);
                else if (pick < 80) send_partial();
                else if (pick < 92) send_noise($urandom_range(1, 6)) ;
                else begin
                    repeat ($urandom_range(1, 40)) begin
                        offer(t_in_item'{CMD_TICK, 8'($urandom)}, CHK_MODEL);
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", pending_results.size(), '0);
        end
        $display("covered %0d items: %0d frames decoded, %0d frames dropped, %0d link reports",
                 n_items, n_frames, n_dropped, n_reports);
        $display("timeouts 0, 6, 25, 3 and all ones, with a long output hold-off; %0d errors",
                 err_count);
        if (err_count == 0) begin
            $display("shunt_frame_decoder_tb OK");
        end else begin
            $display("shunt_frame_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
